### rtl/lers_pkg.sv
// Shared types, constants and interpolation tables of the log/exp range scaler.
`default_nettype none

package lers_pkg;

	// Sample format: signed fixed point, FRAC_BITS fraction bits
	localparam int SAMPLE_WIDTH = 32;
	localparam int FRAC_BITS    = 16;

	// Interpolation tables: TABLE_DEPTH segments, TABLE_DEPTH + 1 points, Q30 entries
	localparam int TABLE_DEPTH = 256;
	localparam int TBL_BITS    = $clog2(TABLE_DEPTH);
	localparam int QBITS       = 30;
	localparam int EXP_W       = 32;  // 2^(i/D) in Q30 reaches 2.0
	localparam int LN_W        = 30;  // ln(1 + i/D) in Q30 reaches at most ln 2
	localparam int EXP_TERMS   = 30;
	localparam int LN_TERMS    = 40;

	localparam logic [63:0] LN2_Q30   = 64'd744261118;
	localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;

	localparam int REG_IDX_W = 3;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	localparam sample_t SMAX  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t SMIN  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam sample_t ONE_Q = SAMPLE_WIDTH'(1 << FRAC_BITS);

	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_LIN  = 2'd1,
		MODE_EXP  = 2'd2,
		MODE_LOG  = 2'd3
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_GAIN   = 3'd1,
		REG_OFFSET = 3'd2,
		REG_FLOOR  = 3'd3,
		REG_CEIL   = 3'd4
	} reg_idx_t;

	// Control that travels with each beat down the pipe
	typedef struct packed {
		logic valid;
		logic blk_end;
	} beat_t;

	typedef logic [TABLE_DEPTH:0][EXP_W-1:0] exp_rom_t;
	typedef logic [TABLE_DEPTH:0][LN_W-1:0]  ln_rom_t;

	// Shift-subtract quotient, used only while building the tables
	function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// 2^(i/D) by the exponential series of i*ln2/D
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t    rom;
		logic [63:0] z;
		logic [63:0] term;
		logic [63:0] sum;
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			z    = (64'(i) * LN2_Q30) >> TBL_BITS;
			term = 64'd1 << QBITS;
			sum  = term;
			for (int n = 1; n <= EXP_TERMS; n++) begin
				term = udiv((term * z) >> QBITS, 64'(n));
				sum  = sum + term;
			end
			rom[i] = EXP_W'(sum);
		end
		return rom;
	endfunction

	// ln(1 + i/D) = 2 * atanh(i / (2D + i)) by its odd series
	function automatic ln_rom_t build_ln_rom();
		ln_rom_t     rom;
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] t;
		logic [63:0] acc;
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			y   = udiv(64'(i) << QBITS, 64'(2 * TABLE_DEPTH + i));
			y2  = (y * y) >> QBITS;
			t   = y;
			acc = '0;
			for (int k = 0; k < LN_TERMS; k++) begin
				acc = acc + udiv(t, 64'(2 * k + 1));
				t   = (t * y2) >> QBITS;
			end
			rom[i] = LN_W'(acc << 1);
		end
		return rom;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();
	localparam ln_rom_t  LN_ROM  = build_ln_rom();

endpackage

`default_nettype wire

### rtl/lers_ln.sv
// Natural log front end, stages 1 to 4: normalize, table lookup, interpolate.
`default_nettype none

module lers_ln
	import lers_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  mode_t   mode,
	input  beat_t   in_beat,
	input  sample_t in_val,
	output beat_t   out_beat,
	output sample_t out_val
);

	localparam int EW    = $clog2(SAMPLE_WIDTH);
	localparam int FW    = QBITS - TBL_BITS;
	localparam int TOT_W = EW + LN_W + 3;

	localparam logic signed [EW+1:0] FRAC_OFF = (EW+2)'(FRAC_BITS);
	localparam logic signed [LN_W:0] LN2_S    = (LN_W+1)'(LN2_Q30);

	beat_t beat_s1, beat_s2, beat_s3, beat_s4;

	sample_t         val_s1, val_s2, val_s3, val_s4;
	logic            pos_s1, pos_s2, pos_s3;
	logic [EW-1:0]   lead_s1, lead_s2;
	logic [QBITS-1:0] frac_s2;
	logic [LN_W-1:0] lo_s3, diff_s3;
	logic [FW-1:0]   wt_s3;
	logic signed [TOT_W-1:0] ebase_s3;

	// Stage 1: top set bit of the sample
	logic [EW-1:0] lead;
	logic          pos;

	always_comb begin
		lead = '0;
		for (int b = 0; b < SAMPLE_WIDTH - 1; b++) begin
			if (in_val[b]) lead = EW'(b);
		end
	end

	assign pos = !in_val[SAMPLE_WIDTH-1] && (in_val != '0);

	// Stage 2: shift so the top bit lands on 1.0 in Q30
	logic [EW-1:0]  shamt;
	logic [QBITS:0] norm;

	assign shamt = EW'(QBITS) - lead_s1;
	assign norm  = val_s1[QBITS:0] << shamt;

	// Stage 3: table points around the mantissa, exponent term
	logic [TBL_BITS-1:0]     idx;
	logic [TBL_BITS:0]       idx_lo, idx_hi;
	logic signed [EW+1:0]    eoff;
	logic signed [TOT_W-1:0] ebase;

	assign idx    = frac_s2[QBITS-1 -: TBL_BITS];
	assign idx_lo = {1'b0, idx};
	assign idx_hi = idx_lo + 1'b1;
	assign eoff   = $signed({2'b00, lead_s2}) - FRAC_OFF;
	assign ebase  = eoff * LN2_S;

	// Stage 4: interpolate, add exponent term, drop to the sample format
	logic [LN_W+FW-1:0]      interp;
	logic [LN_W:0]           lsum;
	logic signed [TOT_W-1:0] total;
	logic signed [TOT_W-1:0] ln_full;
	sample_t                 ln_res;

	assign interp  = diff_s3 * wt_s3;
	assign lsum    = {1'b0, lo_s3} + {1'b0, interp[LN_W+FW-1:FW]};
	assign total   = ebase_s3 + $signed(TOT_W'(lsum));
	assign ln_full = total >>> (QBITS - FRAC_BITS);
	assign ln_res  = ln_full[SAMPLE_WIDTH-1:0];

	// Beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
			beat_s2 <= '0;
			beat_s3 <= '0;
			beat_s4 <= '0;
		end else if (adv) begin
			beat_s1 <= in_beat;
			beat_s2 <= beat_s1;
			beat_s3 <= beat_s2;
			beat_s4 <= beat_s3;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv) begin
			val_s1  <= in_val;
			pos_s1  <= pos;
			lead_s1 <= lead;

			val_s2  <= val_s1;
			pos_s2  <= pos_s1;
			lead_s2 <= lead_s1;
			frac_s2 <= norm[QBITS-1:0];

			val_s3   <= val_s2;
			pos_s3   <= pos_s2;
			lo_s3    <= LN_ROM[idx_lo];
			diff_s3  <= LN_ROM[idx_hi] - LN_ROM[idx_lo];
			wt_s3    <= frac_s2[FW-1:0];
			ebase_s3 <= ebase;

			// non-positive input takes the most negative value
			if (mode == MODE_LOG) begin
				val_s4 <= pos_s3 ? ln_res : SMIN;
			end else begin
				val_s4 <= val_s3;
			end
		end
	end

	assign out_beat = beat_s4;
	assign out_val  = val_s4;

endmodule

`default_nettype wire

### rtl/lers_mul.sv
// Gain and offset, stages 5 to 7: product, truncate and saturate, subtract.
`default_nettype none

module lers_mul
	import lers_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  mode_t   mode,
	input  sample_t gain,
	input  sample_t offset,
	input  beat_t   in_beat,
	input  sample_t in_val,
	output beat_t   out_beat,
	output sample_t out_val
);

	localparam int PW = 2 * SAMPLE_WIDTH;

	localparam logic signed [PW-1:0] RND  = PW'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic signed [PW-1:0] WMAX = PW'(SMAX);
	localparam logic signed [PW-1:0] WMIN = PW'(SMIN);

	beat_t beat_s5, beat_s6, beat_s7;

	logic signed [PW-1:0] prod_s5;
	sample_t              val_s5, val_s6, val_s7;
	sample_t              q_s6;

	// Stage 6: drop fraction bits toward zero, saturate
	logic signed [PW-1:0] biased;
	logic signed [PW-1:0] quo;
	sample_t              q_sat;

	assign biased = prod_s5[PW-1] ? prod_s5 + RND : prod_s5;
	assign quo    = biased >>> FRAC_BITS;

	always_comb begin
		if (quo > WMAX) begin
			q_sat = SMAX;
		end else if (quo < WMIN) begin
			q_sat = SMIN;
		end else begin
			q_sat = quo[SAMPLE_WIDTH-1:0];
		end
	end

	// Stage 7: subtract offset, saturate
	logic signed [SAMPLE_WIDTH:0] dif;
	sample_t                      d_sat;

	assign dif = $signed({q_s6[SAMPLE_WIDTH-1], q_s6}) - $signed({offset[SAMPLE_WIDTH-1], offset});

	always_comb begin
		if (dif[SAMPLE_WIDTH] != dif[SAMPLE_WIDTH-1]) begin
			d_sat = dif[SAMPLE_WIDTH] ? SMIN : SMAX;
		end else begin
			d_sat = dif[SAMPLE_WIDTH-1:0];
		end
	end

	// Beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s5 <= '0;
			beat_s6 <= '0;
			beat_s7 <= '0;
		end else if (adv) begin
			beat_s5 <= in_beat;
			beat_s6 <= beat_s5;
			beat_s7 <= beat_s6;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s5 <= in_val * gain;
			val_s5  <= in_val;

			q_s6   <= q_sat;
			val_s6 <= val_s5;

			val_s7 <= (mode == MODE_PASS) ? val_s6 : d_sat;
		end
	end

	assign out_beat = beat_s7;
	assign out_val  = val_s7;

endmodule

`default_nettype wire

### rtl/lers_exp.sv
// Exponential back end, stages 8 to 11: base-2 split, table lookup, interpolate, scale.
`default_nettype none

module lers_exp
	import lers_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  mode_t   mode,
	input  beat_t   in_beat,
	input  sample_t in_val,
	output beat_t   out_beat,
	output sample_t out_val
);

	localparam int XW  = FRAC_BITS + 8;        // holds +-64.0
	localparam int LW  = 32;
	localparam int MW  = XW + LW;
	localparam int YW  = MW - QBITS;
	localparam int KW  = YW - FRAC_BITS;
	localparam int PW  = FRAC_BITS - TBL_BITS;
	localparam int SHW = $clog2(EXP_W);

	localparam sample_t XLIM   = SAMPLE_WIDTH'(64 << FRAC_BITS);
	localparam sample_t XLIM_N = SAMPLE_WIDTH'(-(64 << FRAC_BITS));
	localparam logic signed [LW-1:0] LOG2E_S = LOG2E_Q30;
	localparam logic signed [KW:0]   SH_OFF  = (KW+1)'(QBITS - FRAC_BITS);
	localparam logic [EXP_W-1:0]     MMAX    = {1'b0, {(EXP_W-1){1'b1}}};
	localparam logic [KW:0]          SH_LIM  = (KW+1)'(EXP_W);

	beat_t beat_s8, beat_s9, beat_s10, beat_s11;

	sample_t              val_s8, val_s9, val_s10, val_s11;
	logic                 over_s8, over_s9, over_s10;
	logic                 under_s8, under_s9, under_s10;
	logic signed [MW-1:0] prod_s8;
	logic [EXP_W-1:0]     lo_s9, diff_s9;
	logic [PW-1:0]        wt_s9;
	logic signed [KW-1:0] k_s9;
	logic [EXP_W-1:0]     m_s10;
	logic signed [KW:0]   sh_s10;

	// Stage 8: range flags, x * log2(e)
	logic signed [XW-1:0] xs;

	assign xs = in_val[XW-1:0];

	// Stage 9: integer and fraction of x*log2(e), table points
	logic signed [MW-1:0] ysh;
	logic [FRAC_BITS-1:0] f;
	logic [TBL_BITS:0]    idx_lo, idx_hi;

	assign ysh    = prod_s8 >>> QBITS;
	assign f      = ysh[FRAC_BITS-1:0];
	assign idx_lo = {1'b0, f[FRAC_BITS-1 -: TBL_BITS]};
	assign idx_hi = idx_lo + 1'b1;

	// Stage 10: interpolated mantissa, output shift
	logic [EXP_W+PW-1:0] interp;
	logic [EXP_W:0]      msum;
	logic signed [KW:0]  sh;

	assign interp = diff_s9 * wt_s9;
	assign msum   = {1'b0, lo_s9} + {1'b0, interp[EXP_W+PW-1:PW]};
	assign sh     = $signed({k_s9[KW-1], k_s9}) - SH_OFF;

	// Stage 11: scale mantissa by 2^shift, saturate
	logic [KW:0] rsh;
	sample_t     ex;

	assign rsh = -sh_s10;

	always_comb begin
		if (over_s10) begin
			ex = SMAX;
		end else if (under_s10) begin
			ex = '0;
		end else if (!sh_s10[KW]) begin
			ex = (sh_s10 != '0 || m_s10 > MMAX) ? SMAX : $signed(m_s10);
		end else if (rsh >= SH_LIM) begin
			ex = '0;
		end else begin
			ex = $signed(m_s10 >> rsh[SHW-1:0]);
		end
	end

	// Beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s8  <= '0;
			beat_s9  <= '0;
			beat_s10 <= '0;
			beat_s11 <= '0;
		end else if (adv) begin
			beat_s8  <= in_beat;
			beat_s9  <= beat_s8;
			beat_s10 <= beat_s9;
			beat_s11 <= beat_s10;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (adv) begin
			val_s8   <= in_val;
			over_s8  <= in_val > XLIM;
			under_s8 <= in_val < XLIM_N;
			prod_s8  <= xs * LOG2E_S;

			val_s9   <= val_s8;
			over_s9  <= over_s8;
			under_s9 <= under_s8;
			lo_s9    <= EXP_ROM[idx_lo];
			diff_s9  <= EXP_ROM[idx_hi] - EXP_ROM[idx_lo];
			wt_s9    <= f[PW-1:0];
			k_s9     <= ysh[FRAC_BITS+KW-1:FRAC_BITS];

			val_s10   <= val_s9;
			over_s10  <= over_s9;
			under_s10 <= under_s9;
			m_s10     <= msum[EXP_W-1:0];
			sh_s10    <= sh;

			val_s11 <= (mode == MODE_EXP) ? ex : val_s10;
		end
	end

	assign out_beat = beat_s11;
	assign out_val  = val_s11;

`ifndef SYNTHESIS
	a_exp_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		adv && beat_s10.valid && mode == MODE_EXP |=> !val_s11[SAMPLE_WIDTH-1])
		else $error("exp result came out negative");
`endif

endmodule

`default_nettype wire

### rtl/log_exp_range_scaler.sv
// Top level of the log/exp range scaler: config registers, pipeline, clip and output stage.
//
// Usage:
//   One signed Q16.16 sample enters per beat on the in_valid/in_ready channel together
//   with its block_end flag; one scaled sample leaves per beat on out_valid/out_ready
//   with block_end_out copied through.  mode selects pass-through, linear, exponential
//   output or logarithmic input scaling; gain, offset, floor_value and ceiling_value
//   are written through cfg_we/cfg_index/cfg_data; the user must write them only while no
//   beat is in flight, as the block itself does not enforce it.  Latency is 12 register
//   stages.  Stages: 4 of log, 3 of gain/offset, 4 of exp and the clip stage, which is
//   also the output register.  Throughput is one sample per cycle while the receiver
//   takes results; every mode runs through the same 12 stages.
//   When the receiver stalls with a result waiting, all stages hold and in_ready
//   drops; nothing is lost or repeated.  Reset empties the pipe and loads the
//   register defaults: mode 0, gain 1.0, offset 0, floor 0, ceiling 1.0.
//   The interpolation tables are constant logic and need no load after reset.
`default_nettype none

module log_exp_range_scaler
	import lers_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [REG_IDX_W-1:0]         cfg_index,
	input  logic [SAMPLE_WIDTH-1:0]      cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                         block_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] scaled,
	output logic                         block_end_out
);

	mode_t   mode_q;
	sample_t gain_q, offset_q, floor_q, ceil_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PASS;
			gain_q   <= ONE_Q;
			offset_q <= '0;
			floor_q  <= '0;
			ceil_q   <= ONE_Q;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
				REG_GAIN:   gain_q   <= cfg_data;
				REG_OFFSET: offset_q <= cfg_data;
				REG_FLOOR:  floor_q  <= cfg_data;
				REG_CEIL:   ceil_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipe advances whenever the output stage is empty or being taken
	logic  adv;
	beat_t in_beat;
	beat_t beat_s4, beat_s7, beat_s11, beat_s12;
	sample_t val_s4, val_s7, val_s11, res_s12;

	assign adv      = !beat_s12.valid || out_ready;
	assign in_ready = adv;
	assign in_beat  = '{valid: in_valid, blk_end: block_end};

	lers_ln u_ln (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.mode     (mode_q),
		.in_beat  (in_beat),
		.in_val   (sample),
		.out_beat (beat_s4),
		.out_val  (val_s4)
	);

	lers_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.mode     (mode_q),
		.gain     (gain_q),
		.offset   (offset_q),
		.in_beat  (beat_s4),
		.in_val   (val_s4),
		.out_beat (beat_s7),
		.out_val  (val_s7)
	);

	lers_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.mode     (mode_q),
		.in_beat  (beat_s7),
		.in_val   (val_s7),
		.out_beat (beat_s11),
		.out_val  (val_s11)
	);

	// Stage 12: outside pass mode, clip to [floor, ceiling]; floor wins when the limits cross
	sample_t clipped;

	always_comb begin
		clipped = val_s11;
		if (clipped > ceil_q) clipped = ceil_q;
		if (clipped < floor_q) clipped = floor_q;
		if (mode_q == MODE_PASS) clipped = val_s11;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s12 <= '0;
		end else if (adv) begin
			beat_s12 <= beat_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s12 <= clipped;
		end
	end

	assign out_valid     = beat_s12.valid;
	assign scaled        = res_s12;
	assign block_end_out = beat_s12.blk_end;

`ifndef SYNTHESIS
	a_clip_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		adv && beat_s11.valid && mode_q != MODE_PASS && floor_q <= ceil_q
		|=> res_s12 >= $past(floor_q) && res_s12 <= $past(ceil_q))
		else $error("clipped result outside floor/ceiling");

	a_beat_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && beat_s11.valid |=> out_valid && block_end_out == $past(beat_s11.blk_end))
		else $error("beat lost between last stage and output");

	a_empty_takes_input: assert property (@(posedge clk) disable iff (!arst_n)
		!beat_s12.valid && !beat_s11.valid |=> !out_valid)
		else $error("output beat appeared from an empty pipe");
`endif

endmodule

`default_nettype wire

### tb/sv/log_exp_range_scaler_tb.sv
// Self-checking testbench for the log/exp range scaler: random traffic, bit-exact prediction.
`timescale 1ns / 100ps

module log_exp_range_scaler_tb;
	import lers_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 7;
	localparam int LATENCY      = 12;
	localparam int IDLE_PCT     = 11;
	localparam int HOLD_CYCLES  = 80;
	localparam int RAND_PHASES  = 14;
	localparam int PHASE_ITEMS  = 75;
	localparam int REPORT_LIMIT = 10;
	localparam longint TIMEOUT_NS = 64'd200_000 * CLK_PERIOD;

	// Table format and series lengths of the exp/ln interpolation tables
	localparam int              TBL_Q      = 30;
	localparam longint unsigned TBL_ONE    = 64'd1 << TBL_Q;
	localparam int              EXP_SERIES = 30;
	localparam int              LN_SERIES  = 40;
	localparam longint          LN2_FX     = 744261118;
	localparam longint          LOG2E_FX   = 1549082005;
	localparam longint          UNIT       = 64'sd1 << FRAC_BITS;
	localparam longint          EXP_LIMIT  = 64 * UNIT;

	localparam logic [REG_IDX_W-1:0] FIRST_SPARE_IDX = REG_IDX_W'(REG_CEIL + 1);
	localparam sample_t NEG_ONE = -ONE_Q;

	typedef struct packed {
		sample_t value;
		logic    last;
	} scaled_beat_t;

	// Expected scaled samples in arrival order, plus the arithmetic that produces them
	class scaled_sample_scoreboard;
		longint unsigned pow2_frac[TABLE_DEPTH+1];
		longint unsigned ln_frac[TABLE_DEPTH+1];
		mode_t           cur_mode;
		longint          cur_gain;
		longint          cur_offset;
		longint          cur_floor;
		longint          cur_ceil;
		scaled_beat_t    pending[$];
		int              mismatches;

		function new();
			longint unsigned ii, z, term, sum, y, y2, t, acc;
			// 2^(i/D) by exp series, ln(1+i/D) by 2*atanh series, both Q30
			for (int i = 0; i <= TABLE_DEPTH; i++) begin
				ii   = i;
				z    = (ii * LN2_FX) / TABLE_DEPTH;
				term = TBL_ONE;
				sum  = TBL_ONE;
				for (int n = 1; n <= EXP_SERIES; n++) begin
					term = ((term * z) >> TBL_Q) / n;
					sum += term;
				end
				pow2_frac[i] = sum;
				y   = (ii << TBL_Q) / (2 * TABLE_DEPTH + ii);
				y2  = (y * y) >> TBL_Q;
				t   = y;
				acc = 0;
				for (int k = 0; k < LN_SERIES; k++) begin
					acc += t / (2 * k + 1);
					t = (t * y2) >> TBL_Q;
				end
				ln_frac[i] = 2 * acc;
			end
			cur_mode   = MODE_PASS;
			cur_gain   = UNIT;
			cur_offset = 0;
			cur_floor  = 0;
			cur_ceil   = UNIT;
			mismatches = 0;
		endfunction

		function longint sat_word(longint v);
			if (v > longint'(SMAX))
				return longint'(SMAX);
			if (v < longint'(SMIN))
				return longint'(SMIN);
			return v;
		endfunction

		// Q product truncated toward zero, then saturated
		function longint mul_fx(longint a, longint b);
			longint prod, mag;
			prod = a * b;
			mag  = (prod < 0) ? -prod : prod;
			mag  = mag >> FRAC_BITS;
			return sat_word((prod < 0) ? -mag : mag);
		endfunction

		function longint exp_fx(longint x);
			longint          y, k, sh;
			longint unsigned frac, pos, idx, wt, mant, v;
			if (x > EXP_LIMIT)
				return longint'(SMAX);
			if (x < -EXP_LIMIT)
				return 0;
			// split x*log2(e) into integer exponent and table fraction
			y    = (x * LOG2E_FX) >>> TBL_Q;
			k    = y >>> FRAC_BITS;
			frac = y - k * UNIT;
			pos  = frac * TABLE_DEPTH;
			idx  = pos >> FRAC_BITS;
			wt   = pos & (UNIT - 1);
			if (idx >= TABLE_DEPTH) begin
				idx = TABLE_DEPTH - 1;
				wt  = UNIT - 1;
			end
			mant = pow2_frac[idx] + (((pow2_frac[idx+1] - pow2_frac[idx]) * wt) >> FRAC_BITS);
			sh   = k + FRAC_BITS - TBL_Q;
			if (sh >= 0) begin
				if (sh >= 32)
					return longint'(SMAX);
				v = mant << sh;
				return (v > longint'(SMAX)) ? longint'(SMAX) : longint'(v);
			end
			if (-sh >= 63)
				return 0;
			return longint'(mant >> (-sh));
		endfunction

		function longint ln_fx(longint s);
			longint unsigned us, norm, u, pos, idx, wt, lv;
			int              e;
			longint          total;
			if (s <= 0)
				return longint'(SMIN);
			us = s;
			e  = 62;
			while (e > 0 && !us[e])
				e--;
			// normalize to 1.u in Q30, interpolate ln(1+u), add exponent * ln2
			norm = (e >= TBL_Q) ? (us >> (e - TBL_Q)) : (us << (TBL_Q - e));
			u    = norm - TBL_ONE;
			pos  = u * TABLE_DEPTH;
			idx  = pos >> TBL_Q;
			wt   = pos & (TBL_ONE - 1);
			if (idx >= TABLE_DEPTH) begin
				idx = TABLE_DEPTH - 1;
				wt  = TBL_ONE - 1;
			end
			lv    = ln_frac[idx] + (((ln_frac[idx+1] - ln_frac[idx]) * wt) >> TBL_Q);
			total = longint'(e - FRAC_BITS) * LN2_FX + longint'(lv);
			return total >>> (TBL_Q - FRAC_BITS);
		endfunction

		// ceiling first, floor wins when the limits cross
		function longint clip_fx(longint v);
			if (v > cur_ceil)
				v = cur_ceil;
			if (v < cur_floor)
				v = cur_floor;
			return v;
		endfunction

		function sample_t scale_sample(sample_t s);
			longint v, r;
			v = s;
			case (cur_mode)
				MODE_LIN: r = clip_fx(sat_word(mul_fx(v, cur_gain) - cur_offset));
				MODE_EXP: r = clip_fx(exp_fx(sat_word(mul_fx(v, cur_gain) - cur_offset)));
				MODE_LOG: r = clip_fx(sat_word(mul_fx(ln_fx(v), cur_gain) - cur_offset));
				default:  r = v;
			endcase
			return sample_t'(r);
		endfunction

		function void apply_reg(logic [REG_IDX_W-1:0] idx, logic [SAMPLE_WIDTH-1:0] data);
			case (idx)
				REG_MODE:   cur_mode   = mode_t'(data[1:0]);
				REG_GAIN:   cur_gain   = longint'(sample_t'(data));
				REG_OFFSET: cur_offset = longint'(sample_t'(data));
				REG_FLOOR:  cur_floor  = longint'(sample_t'(data));
				REG_CEIL:   cur_ceil   = longint'(sample_t'(data));
				default:    ;  // unused index, write dropped
			endcase
		endfunction

		function void note_sample(sample_t s, logic last);
			scaled_beat_t b;
			b.value = scale_sample(s);
			b.last  = last;
			pending.push_back(b);
		endfunction

		function void check_scaled(sample_t got, logic got_last);
			scaled_beat_t b;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected scaled beat %0d last %0b", $time, got, got_last);
				return;
			end
			b = pending.pop_front();
			if (got !== b.value || got_last !== b.last) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: scaled beat mismatch: expected %0d last %0b, got %0d last %0b",
						$time, b.value, b.last, got, got_last);
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		function int error_count();
			return mismatches + pending.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]           cfg_index = REG_MODE;
	logic [SAMPLE_WIDTH-1:0]        cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample = '0;
	logic                           block_end = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] scaled;
	logic                           block_end_out;

	// flow control, written at the falling edge, read at the rising edge
	bit hold_req    = 1'b0;
	bit steady_flow = 1'b0;
	bit tx_steady   = 1'b0;

	scaled_sample_scoreboard scaled_sb = new();

	log_exp_range_scaler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.block_end     (block_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.scaled        (scaled),
		.block_end_out (block_end_out)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	// Result side: check each beat, then pick out_ready for the next cycle
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready)
				scaled_sb.check_scaled(scaled, block_end_out);
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req   = 1'b0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (steady_flow) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offer one beat and hold it until taken; maybe idle one cycle afterwards
	task automatic push_sample(input sample_t s, input logic last);
		in_valid  <= 1'b1;
		sample    <= s;
		block_end <= last;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		scaled_sb.note_sample(s, last);
		if (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending and wait for every pending result, then let the pipe settle
	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (scaled_sb.outstanding() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_flow(input bit tx_s, input bit rx_s, input bit hold);
		@(negedge clk);
		tx_steady   = tx_s;
		steady_flow = rx_s;
		hold_req    = hold;
		@(posedge clk);
	endtask

	// Write all five registers, optionally also an unused index
	task automatic load_regs(input mode_t m, input sample_t g, input sample_t o,
			input sample_t lo, input sample_t hi, input bit spare);
		reg_idx_t                order[5] = '{REG_MODE, REG_GAIN, REG_OFFSET, REG_FLOOR, REG_CEIL};
		logic [SAMPLE_WIDTH-1:0] word[5];
		logic [REG_IDX_W-1:0]    idx;
		word[0]      = $urandom();
		word[0][1:0] = m;
		word[1]      = g;
		word[2]      = o;
		word[3]      = lo;
		word[4]      = hi;
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= word[i];
			@(posedge clk);
			scaled_sb.apply_reg(order[i], word[i]);
		end
		if (spare) begin
			idx = REG_IDX_W'($urandom_range(FIRST_SPARE_IDX, 2**REG_IDX_W - 1));
			word[0] = $urandom();
			cfg_index <= idx;
			cfg_data  <= word[0];
			@(posedge clk);
			scaled_sb.apply_reg(idx, word[0]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic sample_t pick_extreme();
		case ($urandom_range(0, 4))
			0:       return SMIN;
			1:       return SMAX;
			2:       return '0;
			3:       return ONE_Q;
			default: return NEG_ONE;
		endcase
	endfunction

	function automatic sample_t rand_q(input int unsigned span);
		return sample_t'(longint'($urandom_range(0, 2 * span)) - longint'(span));
	endfunction

	// Magnitudes spread over all octaves; mostly positive for the log rule
	function automatic sample_t rand_sample(input mode_t m);
		sample_t v;
		case ($urandom_range(0, 9))
			0: v = $urandom();
			1: v = pick_extreme();
			default: begin
				v = sample_t'($urandom() >> $urandom_range(1, 31));
				if ((m != MODE_LOG || $urandom_range(0, 7) == 0) && $urandom_range(0, 1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	initial begin : stimulus
		mode_t   m;
		sample_t g, o, lo, hi, tmp;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through at reset values
		push_sample(SMAX, 1'b1);
		push_sample(SMIN, 1'b0);
		push_sample('0, 1'b1);
		push_sample(-1, 1'b0);
		drain_pipe();

		// linear with saturating product and subtraction
		load_regs(MODE_LIN, SMAX, SMIN, SMIN, SMAX, 1'b0);
		push_sample(SMAX, 1'b0);
		push_sample(SMIN, 1'b1);
		push_sample(ONE_Q, 1'b0);
		drain_pipe();

		// exp around the +-64 limits and into overflow
		load_regs(MODE_EXP, ONE_Q, '0, SMIN, SMAX, 1'b0);
		push_sample(sample_t'(64 << FRAC_BITS), 1'b0);
		push_sample(sample_t'((64 << FRAC_BITS) + 1), 1'b1);
		push_sample(sample_t'(-(64 << FRAC_BITS) - 1), 1'b0);
		push_sample('0, 1'b0);
		push_sample(sample_t'(20 << FRAC_BITS), 1'b1);
		push_sample(sample_t'(-(10 << FRAC_BITS)), 1'b0);
		drain_pipe();

		// ln of zero, negative, smallest and largest positive
		load_regs(MODE_LOG, ONE_Q, '0, SMIN, SMAX, 1'b0);
		push_sample('0, 1'b0);
		push_sample(-5, 1'b1);
		push_sample(1, 1'b0);
		push_sample(SMAX, 1'b0);
		push_sample(ONE_Q, 1'b1);
		drain_pipe();

		// floor above ceiling; the unused index write must change nothing
		load_regs(MODE_LIN, ONE_Q, '0, ONE_Q, NEG_ONE, 1'b1);
		push_sample('0, 1'b0);
		push_sample(SMAX, 1'b1);

		// random phases: one with no idling, one with a long output hold-off
		for (int p = 0; p < RAND_PHASES; p++) begin
			m = mode_t'(p % 4);
			drain_pipe();
			set_flow(p == 1 || p == 5, p == 1 || p == 5, p == 5);
			g  = ($urandom_range(0, 5) == 0) ? pick_extreme() :
				rand_q(m == MODE_EXP ? (2 << FRAC_BITS) : (16 << FRAC_BITS));
			o  = ($urandom_range(0, 5) == 0) ? pick_extreme() : rand_q(16 << FRAC_BITS);
			lo = rand_q(64 << FRAC_BITS);
			hi = lo + sample_t'($urandom_range(0, 128 << FRAC_BITS));
			case ($urandom_range(0, 5))
				0: begin
					lo = SMIN;
					hi = SMAX;
				end
				1: begin
					tmp = lo;
					lo  = hi;
					hi  = tmp;
				end
				default: ;
			endcase
			load_regs(m, g, o, lo, hi, $urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) push_sample(rand_sample(m), $urandom_range(0, 7) == 0);
		end

		drain_pipe();
		if (scaled_sb.error_count() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/lers_pkg.sv
rtl/lers_ln.sv
rtl/lers_mul.sv
rtl/lers_exp.sv
rtl/log_exp_range_scaler.sv
tb/sv/log_exp_range_scaler_tb.sv
